// ----- rtl/edid_detailed_timing_decoder_defines.svh -----
// assertion macros for the edid detailed timing decoder checker
`ifndef EDID_DETAILED_TIMING_DECODER_DEFINES_SVH
`define EDID_DETAILED_TIMING_DECODER_DEFINES_SVH

// same-cycle implication under reset
`define EDT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edt check failed");

// next-cycle implication under reset
`define EDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("edt check failed");

`endif

// ----- rtl/edt_pkg.sv -----
// shared types and constants for the edid detailed timing decoder
`timescale 1ns / 1ps
package edt_pkg;

  localparam int DescBytes  = 18;
  localparam int HeldCount  = 8;
  localparam int PosW       = 5;
  localparam int HeldAw     = $clog2(HeldCount);
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int DivSteps   = 30;
  localparam int DivCntW    = $clog2(DivSteps);
  localparam int OutW       = 56;

  localparam logic [PosW-1:0]    LastPos    = PosW'(DescBytes - 1);
  localparam logic [13:0]        ClockScale = 14'd10000;

  typedef struct packed {
    logic [15:0] clk_word;
    logic [11:0] h_act;
    logic [11:0] h_blank;
    logic [11:0] v_act;
    logic [11:0] v_blank;
  } desc_t;

endpackage

// ----- rtl/edt_front.sv -----
// byte counter and descriptor capture front end
`timescale 1ns / 1ps
module edt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // desc_byte[7:0]
  input  logic               q_full_i,
  output logic               q_push_o,
  output edt_pkg::desc_t     q_desc_o
);
  import edt_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      held_q [HeldCount];
  logic            last_byte;
  logic            accept;

  assign last_byte     = (pos_q >= LastPos);
  assign s_axis_tready = !(last_byte && q_full_i);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push_o      = accept && last_byte;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last_byte ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (pos_q < PosW'(HeldCount))) begin
      held_q[pos_q[HeldAw-1:0]] <= s_axis_tdata;
    end
  end

  assign q_desc_o.clk_word = {held_q[1], held_q[0]};
  assign q_desc_o.h_act    = {held_q[4][7:4], held_q[2]};
  assign q_desc_o.h_blank  = {held_q[4][3:0], held_q[3]};
  assign q_desc_o.v_act    = {held_q[7][7:4], held_q[5]};
  assign q_desc_o.v_blank  = {held_q[7][3:0], held_q[6]};

endmodule

// ----- rtl/edt_fifo.sv -----
// short descriptor queue between front end and back end
`timescale 1ns / 1ps
module edt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  edt_pkg::desc_t      desc_i,
  input  logic                pop_i,
  output logic                empty_o,
  output edt_pkg::desc_t      desc_o
);
  import edt_pkg::*;

  desc_t                mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ----- rtl/edt_back.sv -----
// refresh rate computation with iterative divider and output register
`timescale 1ns / 1ps
module edt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  edt_pkg::desc_t              q_desc_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [edt_pkg::OutW-1:0]    m_axis_tdata,
  output logic                        m_axis_tuser
);
  import edt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic                m_valid_q;
  logic [OutW-1:0]     m_data_q;
  logic                m_user_q;
  logic                is_mon_q;
  logic                zero_q;
  logic [11:0]         h_act_q, v_act_q;
  logic [12:0]         h_tot_q, v_tot_q;
  logic [25:0]         div_q;
  logic [25:0]         rem_q;
  logic [29:0]         quo_q;
  logic [DivCntW-1:0]  step_q;

  logic [26:0] rem_sh;
  logic        ge;
  logic [26:0] rem_nx;
  logic        out_free;
  logic        tot_zero;

  assign rem_sh   = {rem_q, quo_q[29]};
  assign ge       = (rem_sh >= {1'b0, div_q});
  assign rem_nx   = ge ? rem_sh - {1'b0, div_q} : rem_sh;
  assign out_free = !m_valid_q || m_axis_tready;
  assign tot_zero = (h_tot_q == '0) || (v_tot_q == '0);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      step_q    <= '0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_q  <= '0;
          state_q <= (is_mon_q || tot_zero) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + DivCntW'(1);
          if (step_q == DivCntW'(DivSteps - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          is_mon_q <= (q_desc_i.clk_word == '0);
          h_act_q  <= q_desc_i.h_act;
          v_act_q  <= q_desc_i.v_act;
          h_tot_q  <= {1'b0, q_desc_i.h_act} + {1'b0, q_desc_i.h_blank};
          v_tot_q  <= {1'b0, q_desc_i.v_act} + {1'b0, q_desc_i.v_blank};
          quo_q    <= 30'(q_desc_i.clk_word) * 30'(ClockScale);
        end
      end
      ST_MUL: begin
        div_q  <= 26'(h_tot_q) * 26'(v_tot_q);
        rem_q  <= '0;
        zero_q <= tot_zero;
        if (is_mon_q || tot_zero) begin
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= rem_nx[25:0];
        quo_q <= {quo_q[28:0], ge};
      end
      ST_DONE: begin
        if (out_free) begin
          if (is_mon_q) begin
            m_user_q <= 1'b1;
            m_data_q <= '0;
          end else begin
            m_user_q <= 1'b0;
            m_data_q <= {1'b0, zero_q, quo_q, v_act_q, h_act_q};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/edid_detailed_timing_decoder.sv -----
// top level of the edid detailed timing decoder
//
// input stream: one descriptor byte per transaction, byte 0 first; every
// eighteenth byte closes a descriptor and yields exactly one result.
// output stream: one result per descriptor, decoded timing in 56-bit tdata,
// monitor descriptor flag in tuser.
// the front end takes one byte per cycle while tready is high and parks the
// decoded descriptor fields in a two-entry queue when the last byte arrives.
// the back end pops an entry, adds the totals and scales the pixel clock,
// multiplies the totals, runs a restoring divider at one quotient bit per
// cycle and loads the output register.
// monitor and zero-total descriptors skip the divider.
// the back end handles one descriptor at a time and pops the next entry
// only once it is back in idle.
// when the receiver stalls, the result holds in the output register, the
// back end waits with the next one, the queue takes two more, then tready
// drops on the last byte of the following descriptor.
// reset clears the byte counter, the queue, the back-end state and the output valid.
`timescale 1ns / 1ps
module edid_detailed_timing_decoder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // desc_byte[7:0]
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // h_pixels[11:0], v_lines[23:12], refresh_hz[53:24], zero_total[54]
  output logic [edt_pkg::OutW-1:0] m_axis_tdata,
  output logic                     m_axis_tuser   // is_monitor_desc[0]
);
  import edt_pkg::*;

  logic       q_push;
  logic       q_full;
  desc_t      front_desc;
  desc_t      back_desc;
  logic       q_empty;
  logic       q_pop;

  edt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_desc_o      (front_desc)
  );

  edt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .desc_i  (front_desc),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .desc_o  (back_desc)
  );

  edt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_desc_i      (back_desc),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/edt_checker.sv -----
// port-level checks for the edid detailed timing decoder
`timescale 1ns / 1ps
`include "edid_detailed_timing_decoder_defines.svh"
module edt_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     valid_i,
  input logic                     ready_i,
  input logic [edt_pkg::OutW-1:0] data_i,
  input logic                     user_i
);

  `EDT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_i && !ready_i, valid_i)
  `EDT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, valid_i && !ready_i, $stable({user_i, data_i}))
  `EDT_ASSERT_NOW(a_mon_clean, clk_i, rst_ni, valid_i && user_i, data_i == '0)
  `EDT_ASSERT_NOW(a_zero_rate, clk_i, rst_ni, valid_i && data_i[54], data_i[53:24] == '0)
  `EDT_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, valid_i, data_i[55] == 1'b0)

endmodule

bind edid_detailed_timing_decoder edt_checker u_edt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (m_axis_tvalid),
  .ready_i (m_axis_tready),
  .data_i  (m_axis_tdata),
  .user_i  (m_axis_tuser)
);
